// File: hw/rtl/nsr_pkg.sv
// Shared types and constants for the Newton square root unit.
package nsr_pkg;

   localparam int RAD_W          = 32;
   localparam int ROOT_W         = 24;
   localparam int TOL_W          = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int MAX_ITER_DEF   = 32;
   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_UPDATE
   } nsr_state_type;

   typedef struct packed {
      logic load;       // capture radicand, seed estimate
      logic div_init;   // preload divider with the scaled radicand
      logic div_step;   // one restoring division step
      logic update;     // estimate takes the new value
      logic emit;       // register a result item
      logic emit_zero;  // result root is forced to zero
      logic emit_conv;  // result converged flag
   } nsr_cmd_type;

   typedef struct packed {
      logic rad_zero;
      logic x_zero;
      logic conv_hit;
   } nsr_status_type;

endpackage

// File: hw/rtl/nsr_datapath.sv
// Datapath: estimate register, serial restoring divider, step update and result registers.
module nsr_datapath
   import nsr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  nsr_cmd_type          cmd,
   input  logic [RAD_W-1:0]     req_radicand,
   input  logic [TOL_W-1:0]     tol,
   output nsr_status_type       status,
   output logic                 rsp_valid,
   output logic [ROOT_W-1:0]    rsp_root,
   output logic                 rsp_converged
);

   localparam int NW = RAD_W + FRAC_BITS;

   logic [NW-1:0]     num_ff, num_in;
   logic [NW-1:0]     x_ff, x_in;
   logic [NW:0]       rem_ff, rem_in;
   logic [NW-1:0]     quo_ff, quo_in;
   logic              rad_zero_ff, rad_zero_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROOT_W-1:0] rsp_root_ff, rsp_root_in;
   logic              rsp_conv_ff, rsp_conv_in;

   logic [NW:0]       trial;
   logic              fits;
   logic [NW:0]       sum;
   logic [NW-1:0]     next_x;
   logic [NW-1:0]     diff;
   logic [ROOT_W-1:0] root_sat;

   // restoring step: shift the next dividend bit into the partial remainder
   assign trial = {rem_ff[NW-1:0], quo_ff[NW-1]};
   assign fits  = (trial >= {1'b0, x_ff});

   // x' = (x + q) / 2, q being the finished quotient
   assign sum    = {1'b0, x_ff} + {1'b0, quo_ff};
   assign next_x = sum[NW:1];
   assign diff   = (next_x > x_ff) ? (next_x - x_ff) : (x_ff - next_x);

   assign root_sat = (|next_x[NW-1:ROOT_W]) ? {ROOT_W{1'b1}} : next_x[ROOT_W-1:0];

   always_comb begin
      num_in       = num_ff;
      x_in         = x_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      rad_zero_in  = rad_zero_ff;
      rsp_valid_in = cmd.emit;
      rsp_root_in  = rsp_root_ff;
      rsp_conv_in  = rsp_conv_ff;

      if (cmd.load) begin
         num_in      = {req_radicand, FRAC_BITS'(0)};
         x_in        = NW'(req_radicand);
         rad_zero_in = (req_radicand == '0);
      end
      if (cmd.div_init) begin
         rem_in = '0;
         quo_in = num_ff;
      end
      if (cmd.div_step) begin
         rem_in = fits ? (trial - {1'b0, x_ff}) : trial;
         quo_in = {quo_ff[NW-2:0], fits};
      end
      if (cmd.update) begin
         x_in = next_x;
      end
      if (cmd.emit) begin
         rsp_root_in = cmd.emit_zero ? '0 : root_sat;
         rsp_conv_in = cmd.emit_conv;
      end
   end

   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      x_ff        <= x_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rad_zero_ff <= rad_zero_in;
      rsp_root_ff <= rsp_root_in;
      rsp_conv_ff <= rsp_conv_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.rad_zero = rad_zero_ff;
   assign status.x_zero   = (x_ff == '0);
   assign status.conv_hit = (diff <= NW'(tol));

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_root      = rsp_root_ff;
   assign rsp_converged = rsp_conv_ff;

endmodule

// File: hw/rtl/nsr_controller.sv
// Controller: sequences Newton steps and the bit steps of the serial divider.
module nsr_controller
   import nsr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int MAX_ITER  = MAX_ITER_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  nsr_status_type status,
   output nsr_cmd_type    cmd,
   output logic           busy
);

   localparam int NW      = RAD_W + FRAC_BITS;
   localparam int BIT_CW  = $clog2(NW);
   localparam int ITER_CW = $clog2(MAX_ITER);

   nsr_state_type      state_ff, state_in;
   logic [BIT_CW-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [ITER_CW-1:0] iter_cnt_ff, iter_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         bit_cnt_ff  <= '0;
         iter_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         bit_cnt_ff  <= bit_cnt_in;
         iter_cnt_ff <= iter_cnt_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      bit_cnt_in  = bit_cnt_ff;
      iter_cnt_in = iter_cnt_ff;
      cmd         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load    = 1'b1;
               iter_cnt_in = '0;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.rad_zero) begin
               cmd.emit      = 1'b1;
               cmd.emit_zero = 1'b1;
               cmd.emit_conv = 1'b1;
               state_in      = ST_IDLE;
            end else if (status.x_zero) begin
               // guard only; a nonzero radicand never drives the estimate to zero
               cmd.emit      = 1'b1;
               cmd.emit_zero = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.div_init = 1'b1;
               bit_cnt_in   = '0;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            bit_cnt_in   = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BIT_CW'(NW - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (status.conv_hit) begin
               cmd.emit      = 1'b1;
               cmd.emit_conv = 1'b1;
               state_in      = ST_IDLE;
            end else if (iter_cnt_ff == ITER_CW'(MAX_ITER - 1)) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end else begin
               iter_cnt_in = iter_cnt_ff + 1'b1;
               state_in    = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   // an update is only entered from the division state, which runs its full bit count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> $past(state_ff == ST_DIV))
      else $error("update entered without a finished division");

   // an emit always brings the sequencer back to idle
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after a result");

   // a zero radicand never starts the divider
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && status.rad_zero) |-> !cmd.div_init)
      else $error("divider started on a zero radicand");

endmodule

// File: hw/rtl/newton_square_root_unit.sv
// Top level of the Newton square root unit: ports, tolerance register, controller and datapath.
// Sequence: a zero radicand goes from the check straight to its result. Otherwise each Newton
// step runs check, 32+FRAC_BITS divider bits and update; an item takes 1 to MAX_ITER steps.
// Throughput: one item at a time, set by the one-bit-per-cycle serial divider; a new item
// may start in the cycle its result strobe is high. The receiver cannot stall the result.
// Reset (synchronous, active high) returns to idle, drops the strobe, tolerance goes to 1.
module newton_square_root_unit
   import nsr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int MAX_ITER  = MAX_ITER_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // item input
   input  logic              start,
   output logic              busy,
   input  logic [RAD_W-1:0]  req_radicand,
   // result, one-cycle strobe
   output logic              rsp_valid,
   output logic [ROOT_W-1:0] rsp_root,
   output logic              rsp_converged,
   // tolerance register write
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [TOL_W-1:0]  csr_wdata
);

   nsr_cmd_type      cmd;
   nsr_status_type   status;
   logic [TOL_W-1:0] tol_ff, tol_in;

   // Tolerance register: always writable, only written while idle by contract.
   assign csr_ready = 1'b1;
   assign tol_in    = (csr_valid && csr_ready) ? csr_wdata : tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   // Sequencer: walks check -> divide -> update per Newton step.
   nsr_controller #(
      .FRAC_BITS (FRAC_BITS),
      .MAX_ITER  (MAX_ITER)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Estimate, divider and result registers.
   nsr_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_radicand  (req_radicand),
      .tol           (tol_ff),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_root      (rsp_root),
      .rsp_converged (rsp_converged)
   );

   // A result only follows work in progress.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without an item in progress");

   // One result per item: the strobe is never high back to back.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // An accepted item always makes the unit busy.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not start work");

endmodule
